/* hdl/assert_macros.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/prs_pkg.sv */
// Package with types, constants and helpers of the rank scheduler.
package prs_pkg;
	localparam int unsigned MaxPackets = 1024;
	localparam int unsigned AddrW = $clog2(MaxPackets);
	localparam int unsigned CountW = AddrW + 1;
	localparam logic [31:0] ByteLimitReset = 32'd2500000;

	typedef enum logic [1:0] {
		CMD_ENQ = 2'd0,
		CMD_DEQ = 2'd1,
		CMD_FLUSH = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ENQUEUED = 3'd0,
		ST_DROP_LIMIT = 3'd1,
		ST_DROP_FULL = 3'd2,
		ST_DEQUEUED = 3'd3,
		ST_EMPTY = 3'd4,
		ST_FLUSHED = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0] command;
		logic [15:0] packet_handle;
		logic [15:0] packet_length;
		logic is_ipv4;
		logic [15:0] ip_ident;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [15:0] out_handle;
		logic [15:0] out_rank;
		logic [15:0] out_length;
		logic head_valid;
		logic [15:0] head_handle;
		logic [15:0] head_rank;
		logic [31:0] backlog_total;
		logic [10:0] queued_count;
		logic [31:0] dropped_new_count;
	} out_item_t;

	// One heap entry as stored in memory.
	typedef struct packed {
		logic [15:0] seq;
		logic [15:0] length;
		logic [15:0] rank;
		logic [15:0] handle;
	} entry_t;

	// Sequencer states of the heap engine.
	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LOAD,
		S_DN_WAIT,
		S_DN_CMP,
		S_PLACE,
		S_DONE
	} state_t;

	// Request from the controller to the heap engine.
	typedef struct packed {
		logic push;
		logic pop;
		entry_t ent;
		logic [CountW-1:0] count;
	} heap_req_t;

	// True if entry a must leave before entry b.
	function automatic logic earlier(entry_t a, entry_t b);
		logic [15:0] d;
		d = a.seq - b.seq;
		if (a.rank != b.rank) return a.rank < b.rank;
		return d[15];
	endfunction
endpackage

/* hdl/prs_heap.sv */
// Heap engine: min-heap held in one memory, sifted one level at a time, each level a read state then a compare state.
`include "assert_macros.svh"
module prs_heap (
	input logic clk,
	input logic arst_n,
	input prs_pkg::heap_req_t req,
	output logic done,
	output prs_pkg::entry_t head
);
	import prs_pkg::*;

	entry_t mem [MaxPackets];
	logic we;
	logic [AddrW-1:0] waddr, raddr;
	entry_t wdata, rdata_q;

	state_t state_q, state_d;
	logic [AddrW-1:0] idx_q, idx_d;
	logic [CountW-1:0] cnt_q, cnt_d;
	entry_t cur_q, cur_d, left_q, left_d;
	entry_t head_q, head_d;

	// Child and parent indices of the current node; the right child may pass the end.
	logic [CountW-1:0] lc;
	logic [CountW:0] rc;
	logic [AddrW-1:0] par;
	logic up_swap, take_l, take_r, dn_move, dn_more;
	entry_t best_l;
	logic [AddrW-1:0] dn_idx;
	logic [CountW-1:0] dn_lc;
	logic [CountW-1:0] last;

	assign lc = {idx_q, 1'b1};
	assign rc = {1'b0, lc} + (CountW+1)'(1);
	assign par = (idx_q - AddrW'(1)) >> 1;
	assign last = req.count - CountW'(1);

	// Sift up: the moving entry against its parent.
	assign up_swap = earlier(cur_q, rdata_q);

	// Sift down: left child held in left_q, right child arriving in rdata_q.
	assign take_l = earlier(left_q, cur_q);
	assign best_l = take_l ? left_q : cur_q;
	assign take_r = (rc < {1'b0, cnt_q}) && earlier(rdata_q, best_l);
	assign dn_move = take_l || take_r;
	assign dn_idx = take_r ? AddrW'(rc) : AddrW'(lc);
	assign dn_lc = {dn_idx, 1'b1};
	assign dn_more = dn_lc < cnt_q;

	// Heap memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		cnt_q <= cnt_d;
		cur_q <= cur_d;
		left_q <= left_d;
		head_q <= head_d;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.push) state_d = (req.count == '0) ? S_PLACE : S_UP_RD;
				else if (req.pop) state_d = (req.count == CountW'(1)) ? S_DONE : S_DN_LOAD;
			end
			S_UP_RD: state_d = S_UP_CMP;
			S_UP_CMP: begin
				if (!up_swap) state_d = S_DONE;
				else if (par == '0) state_d = S_PLACE;
				else state_d = S_UP_RD;
			end
			S_DN_LOAD: state_d = (cnt_q > CountW'(1)) ? S_DN_WAIT : S_PLACE;
			S_DN_WAIT: state_d = S_DN_CMP;
			S_DN_CMP: begin
				if (!dn_move) state_d = S_DONE;
				else if (dn_more) state_d = S_DN_WAIT;
				else state_d = S_PLACE;
			end
			S_PLACE: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath and memory control. The moving entry stays in cur_q and is
	// written once, where it finally lands.
	always_comb begin
		idx_d = idx_q;
		cnt_d = cnt_q;
		cur_d = cur_q;
		left_d = left_q;
		we = 1'b0;
		waddr = idx_q;
		wdata = cur_q;
		raddr = par;
		unique case (state_q)
			S_IDLE: begin
				if (req.push) begin
					idx_d = AddrW'(req.count);
					cur_d = req.ent;
				end else if (req.pop) begin
					// Read the last entry; it refills the root.
					idx_d = '0;
					cnt_d = last;
					raddr = AddrW'(last);
				end
			end
			S_UP_RD: raddr = par;
			S_UP_CMP: begin
				we = 1'b1;
				if (up_swap) begin
					// Parent moves down into the hole.
					wdata = rdata_q;
					idx_d = par;
				end
			end
			S_DN_LOAD: begin
				cur_d = rdata_q;
				raddr = AddrW'(1);
			end
			S_DN_WAIT: begin
				left_d = rdata_q;
				raddr = AddrW'(rc);
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (dn_move) begin
					// Earlier child moves up; read the left child of its old place.
					wdata = take_r ? rdata_q : left_q;
					idx_d = dn_idx;
					raddr = AddrW'(dn_lc);
				end
			end
			S_PLACE: we = 1'b1;
			default: ;
		endcase
	end

	// The head register mirrors memory entry zero.
	assign head_d = (we && waddr == '0) ? wdata : head_q;
	assign head = head_q;
	assign done = (state_q == S_DONE);

	`ASSERT_NEXT(a_done_idle, clk, arst_n, state_q == S_DONE, state_q == S_IDLE,
		"heap done not followed by idle")
	`ASSERT_IMPLY(a_no_req_busy, clk, arst_n, state_q != S_IDLE, !req.push && !req.pop,
		"request while the heap is busy")
	`ASSERT_IMPLY(a_one_req, clk, arst_n, 1'b1, !(req.push && req.pop),
		"push and pop together")
	`ASSERT_IMPLY(a_dn_child, clk, arst_n, state_q == S_DN_CMP, lc < cnt_q,
		"compare without a left child")
endmodule

/* hdl/pifo_rank_packet_scheduler.sv */
// Top level of the rank scheduler: command control, counters and result register.
//  channel | signals                          | transfer
//  cmd     | start, busy, cmd_in              | start & !busy
//  result  | result_valid, result             | result_valid, one cycle
//  config  | cfg_we, cfg_wdata                | cfg_we
// Drops, flush, empty and the unused command finish without the heap. An enqueue
// waits on the heap while the new entry rises, each level a parent read, then a
// compare and write; a dequeue waits while the refilled root sinks, each level a
// left read, then a right read under the compare.
// The result strobe rises as busy falls.
// Reset clears counters and control and sets the byte limit; heap memory is never cleared.
// The result cannot be stalled; it shows for exactly one cycle.
`include "assert_macros.svh"
module pifo_rank_packet_scheduler (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input prs_pkg::in_item_t cmd_in,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	output logic result_valid,
	output prs_pkg::out_item_t result
);
	import prs_pkg::*;

	logic [31:0] limit_q, backlog_q, drops_q;
	logic [15:0] seq_q;
	logic [CountW-1:0] count_q;
	logic busy_q, wait_q, deq_q;
	status_t status_q;
	entry_t popped_q;
	heap_req_t req;
	logic hdone;
	entry_t head;
	logic [32:0] sum;
	status_t st;
	logic go, finish;
	logic rv_q;

	assign go = start && !busy_q;
	assign finish = busy_q && (!wait_q || hdone);
	assign sum = {1'b0, backlog_q} + {17'd0, cmd_in.packet_length};

	prs_heap u_heap (.clk(clk), .arst_n(arst_n), .req(req), .done(hdone), .head(head));

	// Command decode and heap request.
	always_comb begin
		st = ST_EMPTY;
		req = '0;
		req.count = count_q;
		req.ent.handle = cmd_in.packet_handle;
		req.ent.rank = cmd_in.is_ipv4 ? cmd_in.ip_ident : 16'd0;
		req.ent.length = cmd_in.packet_length;
		req.ent.seq = seq_q;
		case (cmd_in.command)
			CMD_ENQ: begin
				if (sum > {1'b0, limit_q}) st = ST_DROP_LIMIT;
				else if (count_q >= CountW'(MaxPackets)) st = ST_DROP_FULL;
				else st = ST_ENQUEUED;
			end
			CMD_DEQ: st = (count_q != '0) ? ST_DEQUEUED : ST_EMPTY;
			CMD_FLUSH: st = ST_FLUSHED;
			default: st = ST_EMPTY;
		endcase
		req.push = go && (st == ST_ENQUEUED);
		req.pop = go && (st == ST_DEQUEUED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ByteLimitReset;
			backlog_q <= '0;
			drops_q <= '0;
			seq_q <= '0;
			count_q <= '0;
			busy_q <= 1'b0;
			wait_q <= 1'b0;
			rv_q <= 1'b0;
		end else begin
			rv_q <= finish;
			if (cfg_we) limit_q <= cfg_wdata;
			if (go) begin
				busy_q <= 1'b1;
				wait_q <= req.push || req.pop;
				case (st) inside
					ST_DROP_LIMIT, ST_DROP_FULL: drops_q <= drops_q + 32'd1;
					ST_ENQUEUED: begin
						seq_q <= seq_q + 16'd1;
						count_q <= count_q + CountW'(1);
						backlog_q <= sum[31:0];
					end
					ST_DEQUEUED: count_q <= count_q - CountW'(1);
					ST_FLUSHED: begin
						count_q <= '0;
						backlog_q <= '0;
					end
					default: ;
				endcase
			end else if (finish) begin
				busy_q <= 1'b0;
				wait_q <= 1'b0;
				if (deq_q) backlog_q <= backlog_q - {16'd0, popped_q.length};
			end
		end
	end

	// Popped entry is the head before the pop starts.
	always_ff @(posedge clk) begin
		if (go) begin
			popped_q <= head;
			deq_q <= (st == ST_DEQUEUED);
			status_q <= st;
		end
	end

	// Result assembly.
	always_comb begin
		result = '0;
		result.status = status_q;
		if (deq_q) begin
			result.out_handle = popped_q.handle;
			result.out_rank = popped_q.rank;
			result.out_length = popped_q.length;
		end
		result.head_valid = (count_q != '0);
		if (count_q != '0) begin
			result.head_handle = head.handle;
			result.head_rank = head.rank;
		end
		result.backlog_total = backlog_q;
		result.queued_count = 11'(count_q);
		result.dropped_new_count = drops_q;
	end

	assign busy = busy_q;
	assign result_valid = rv_q;

	`ASSERT_NEXT(a_go_busy, clk, arst_n, go, busy_q, "accepted command not busy")
	`ASSERT_IMPLY(a_cnt_max, clk, arst_n, 1'b1, count_q <= CountW'(MaxPackets),
		"count beyond capacity")
	`ASSERT_IMPLY(a_rv_idle, clk, arst_n, rv_q, !busy_q, "result while busy")
endmodule

/* tb/prs_checker.sv */
// Checker for the rank scheduler: predicts each result from accepted commands and compares.
module prs_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input prs_pkg::in_item_t cmd_in,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input logic result_valid,
	input prs_pkg::out_item_t result,
	output int unsigned fail_count,
	output int unsigned pending_count,
	output int unsigned dequeue_seen,
	output int unsigned drop_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import prs_pkg::*;

	// Predicted queue contents and counters.
	entry_t heap_model[MaxPackets];
	int unsigned model_count;
	logic [31:0] model_backlog;
	logic [15:0] model_seq;
	logic [31:0] model_drops;
	logic [31:0] model_limit;
	out_item_t expected_results[$];

	function automatic logic leaves_first(entry_t a, entry_t b);
		logic [15:0] diff;
		diff = a.seq - b.seq;
		if (a.rank != b.rank) return a.rank < b.rank;
		return diff >= 16'h8000;
	endfunction

	// Apply one command to the predicted queue and return the expected result.
	function automatic out_item_t predict_schedule(in_item_t item);
		out_item_t res;
		entry_t ent, tmp;
		int unsigned i, p, l, r, m;
		logic [15:0] rank;
		res = '0;
		res.status = ST_EMPTY;
		rank = item.is_ipv4 ? item.ip_ident : 16'd0;
		case (cmd_t'(item.command))
			CMD_ENQ: begin
				if ({1'b0, model_backlog} + item.packet_length > {1'b0, model_limit}) begin
					res.status = ST_DROP_LIMIT;
					model_drops++;
				end else if (model_count >= MaxPackets) begin
					res.status = ST_DROP_FULL;
					model_drops++;
				end else begin
					ent.handle = item.packet_handle;
					ent.rank = rank;
					ent.length = item.packet_length;
					ent.seq = model_seq;
					i = model_count;
					heap_model[i] = ent;
					model_count++;
					while (i > 0) begin
						p = (i - 1) / 2;
						if (!leaves_first(heap_model[i], heap_model[p])) break;
						tmp = heap_model[i];
						heap_model[i] = heap_model[p];
						heap_model[p] = tmp;
						i = p;
					end
					model_seq++;
					model_backlog += item.packet_length;
					res.status = ST_ENQUEUED;
				end
			end
			CMD_DEQ: begin
				if (model_count > 0) begin
					ent = heap_model[0];
					res.out_handle = ent.handle;
					res.out_rank = ent.rank;
					res.out_length = ent.length;
					model_count--;
					heap_model[0] = heap_model[model_count];
					i = 0;
					forever begin
						l = 2 * i + 1;
						r = l + 1;
						m = i;
						if (l < model_count && leaves_first(heap_model[l], heap_model[m])) m = l;
						if (r < model_count && leaves_first(heap_model[r], heap_model[m])) m = r;
						if (m == i) break;
						tmp = heap_model[i];
						heap_model[i] = heap_model[m];
						heap_model[m] = tmp;
						i = m;
					end
					model_backlog -= ent.length;
					res.status = ST_DEQUEUED;
				end
			end
			CMD_FLUSH: begin
				model_count = 0;
				model_backlog = '0;
				res.status = ST_FLUSHED;
			end
			default: ;
		endcase
		if (model_count > 0) begin
			res.head_valid = 1'b1;
			res.head_handle = heap_model[0].handle;
			res.head_rank = heap_model[0].rank;
		end
		res.backlog_total = model_backlog;
		res.queued_count = model_count[10:0];
		res.dropped_new_count = model_drops;
		return res;
	endfunction

	// Watch the command, config and result channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_res;
		if (!arst_n) begin
			model_count = 0;
			model_backlog = '0;
			model_seq = '0;
			model_drops = '0;
			model_limit = ByteLimitReset;
			expected_results.delete();
			fail_count <= 0;
			pending_count <= 0;
			dequeue_seen <= 0;
			drop_seen <= 0;
		end else begin
			if (cfg_we) model_limit = cfg_wdata;
			if (result_valid) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, result);
					fail_count <= fail_count + 1;
				end else begin
					exp_res = expected_results.pop_front();
					if (result !== exp_res) begin
						$display("%0t: result mismatch, expected %p, actual %p",
							$time, exp_res, result);
						fail_count <= fail_count + 1;
					end
					if (exp_res.status == ST_DEQUEUED) dequeue_seen <= dequeue_seen + 1;
					if (exp_res.status inside {ST_DROP_LIMIT, ST_DROP_FULL})
						drop_seen <= drop_seen + 1;
				end
			end
			if (start && !busy) expected_results.push_back(predict_schedule(cmd_in));
			pending_count <= expected_results.size();
		end
	end
endmodule

/* tb/testbench.sv */
// Top of the rank scheduler testbench: clock, reset, command stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import prs_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t cmd_in;
	logic cfg_we;
	logic [31:0] cfg_wdata;
	logic result_valid;
	out_item_t result;
	int unsigned fail_count, pending_count, dequeue_seen, drop_seen;
	int unsigned idle_pct;
	int unsigned item_total;

	pifo_rank_packet_scheduler i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.result_valid(result_valid), .result(result)
	);

	prs_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.result_valid(result_valid), .result(result),
		.fail_count(fail_count), .pending_count(pending_count),
		.dequeue_seen(dequeue_seen), .drop_seen(drop_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// One command transfer, with a random idle gap first. Start stays high after
	// the transfer until an idle gap or a drain lowers it.
	task automatic send_command(input cmd_t op, input logic [15:0] handle,
		input logic [15:0] len, input logic ipv4, input logic [15:0] ident);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < idle_pct) @(negedge clk);
		end
		cmd_in <= '{command: op, packet_handle: handle, packet_length: len,
			is_ipv4: ipv4, ip_ident: ident};
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		item_total++;
	endtask

	// Random command mostly well formed: ranks from a small set to force ties.
	task automatic send_random(input int unsigned enq_pct, input int unsigned len_max);
		int unsigned pick;
		logic [15:0] ident;
		pick = $urandom_range(99);
		ident = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
		if (pick < enq_pct)
			send_command(CMD_ENQ, 16'($urandom), 16'($urandom_range(len_max)),
				1'($urandom), ident);
		else if (pick < 97)
			send_command(CMD_DEQ, 16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
		else if (pick < 99)
			send_command(CMD_FLUSH, 16'($urandom), 16'($urandom), 1'($urandom),
				16'($urandom));
		else
			send_command(CMD_NONE, 16'($urandom), 16'($urandom), 1'($urandom),
				16'($urandom));
	endtask

	// Stop sending, wait until every expected result is back, then let the engine settle.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_limit(input logic [31:0] value);
		drain_results();
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned phase;
		arst_n = 1'b0;
		start = 1'b0;
		cmd_in = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_pct = 0;
		item_total = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: field extremes, ties, empty dequeue, unused command, flush.
		send_command(CMD_DEQ, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
		send_command(CMD_ENQ, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
		send_command(CMD_ENQ, 16'h0000, 16'h0000, 1'b0, 16'hFFFF);
		send_command(CMD_ENQ, 16'h1234, 16'd100, 1'b1, 16'd5);
		send_command(CMD_ENQ, 16'h1235, 16'd200, 1'b1, 16'd5);
		send_command(CMD_ENQ, 16'h1236, 16'd1, 1'b0, 16'd0);
		send_command(CMD_NONE, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
		repeat (6) send_command(CMD_DEQ, 16'h0, 16'h0, 1'b0, 16'h0);
		send_command(CMD_ENQ, 16'h00AA, 16'd10, 1'b1, 16'd0);
		send_command(CMD_FLUSH, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
		send_command(CMD_DEQ, 16'h0, 16'h0, 1'b0, 16'h0);

		// Byte limit extremes: zero drops all but empty packets, small limit drops on sum.
		write_limit(32'd0);
		send_command(CMD_ENQ, 16'h0001, 16'd1, 1'b1, 16'd3);
		send_command(CMD_ENQ, 16'h0002, 16'd0, 1'b1, 16'd3);
		write_limit(32'd300);
		send_command(CMD_ENQ, 16'h0003, 16'd300, 1'b1, 16'd2);
		send_command(CMD_ENQ, 16'h0004, 16'd1, 1'b1, 16'd1);
		// Lowered below the backlog: queued packets stay.
		write_limit(32'd10);
		send_command(CMD_DEQ, 16'h0, 16'h0, 1'b0, 16'h0);
		send_command(CMD_FLUSH, 16'h0, 16'h0, 1'b0, 16'h0);
		write_limit(32'hFFFF_FFFF);

		// Fill the store to force full-store drops, then a few more.
		idle_pct = 0;
		repeat (MaxPackets + 3)
			send_command(CMD_ENQ, 16'($urandom), 16'($urandom), 1'($urandom),
				16'($urandom_range(15)));
		repeat (40) send_command(CMD_DEQ, 16'h0, 16'h0, 1'b0, 16'h0);
		send_command(CMD_FLUSH, 16'h0, 16'h0, 1'b0, 16'h0);

		// Random phases across limits and idle rates.
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: idle_pct = 0;
				1: idle_pct = 65;
				2: idle_pct = 22;
				default: idle_pct = 0;
			endcase
			case (phase)
				2: write_limit(32'd40000);
				4: write_limit(32'd2500000);
				6: write_limit(32'd1000);
				default: ;
			endcase
			repeat (120) send_random((phase % 2) ? 50 : 65, (phase == 6) ? 300 : 65535);
			if (phase == 3) drain_results();
		end

		drain_results();
		$display("Ran %0d commands: %0d dequeues and %0d drops checked,", item_total,
			dequeue_seen, drop_seen);
		$display("covering ties, full store, several byte limits and idle patterns.");
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end
endmodule
